// File: hw/rtl/cbrc_pkg.sv
// ----------------------------------------------------------------------------
// cbrc_pkg
// Request and result types and fixed codes of the coding-block result cache.
// ----------------------------------------------------------------------------
package cbrc_pkg;

    // request kinds
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_INVAL  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // entry geometry: four quadrants, five partitions each
    localparam int QUADS     = 4;
    localparam int PARTS     = 5;
    localparam int PER_DEPTH = QUADS * PARTS;

    // partition codes
    localparam logic [2:0] PART_FULL = 3'd0;
    localparam logic [2:0] PART_HOR0 = 3'd1;
    localparam logic [2:0] PART_HOR1 = 3'd2;
    localparam logic [2:0] PART_VER0 = 3'd3;
    localparam logic [2:0] PART_VER1 = 3'd4;

    // sticky feature bits kept in the metadata word
    localparam int FEAT_W     = 3;
    localparam int FEAT_INTRA = 0;
    localparam int FEAT_INTER = 1;
    localparam int FEAT_SKIP  = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic        tree;
        logic [12:0] pos_x;
        logic [12:0] pos_y;
        logic [2:0]  log2_width;
        logic [2:0]  log2_height;
        logic        is_intra;
        logic        is_inter;
        logic        skip_flag;
        logic [31:0] payload;
        logic [2:0]  clr_depth;
    } cbrc_req_t;

    typedef struct packed {
        logic        found;
        logic        hit;
        logic [31:0] cached_payload;
        logic        saw_intra;
        logic        saw_inter;
        logic        saw_skip;
        logic        stored;
    } cbrc_rsp_t;

endpackage

// File: hw/rtl/cbrc_ram.sv
// ----------------------------------------------------------------------------
// cbrc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cbrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cbrc_locate.sv
// ----------------------------------------------------------------------------
// cbrc_locate
// Map a block position and shape to a cache entry index.
// ----------------------------------------------------------------------------
module cbrc_locate
    import cbrc_pkg::*;
#(
    parameter int CTU_LOG2 = 6,
    parameter int TREES    = 2,
    parameter int IDX_W    = 8
) (
    input  logic             tree,
    input  logic [12:0]      pos_x,
    input  logic [12:0]      pos_y,
    input  logic [2:0]       log2_width,
    input  logic [2:0]       log2_height,
    output logic             found,
    output logic [IDX_W-1:0] idx
);

    localparam int DEPTHS = CTU_LOG2 - 1;

    logic [3:0]  lw4;
    logic [3:0]  lh4;
    logic [12:0] hmask;
    logic [12:0] vmask;
    logic [2:0]  part;
    logic        shape_ok;
    logic [2:0]  big;
    logic [3:0]  depth;
    logic        depth_ok;
    logic        tree_ok;
    logic [1:0]  quad;
    logic [IDX_W-1:0] td;
    logic [IDX_W-1:0] tdq;

    always_comb begin
        lw4      = {1'b0, log2_width};
        lh4      = {1'b0, log2_height};
        hmask    = (13'd1 << (lh4 + 4'd1)) - 13'd1;
        vmask    = (13'd1 << (lw4 + 4'd1)) - 13'd1;
        shape_ok = 1'b1;
        part     = PART_FULL;
        if (lw4 == lh4) begin
            part = PART_FULL;
        end else if (lw4 == lh4 + 4'd1) begin
            part = ((pos_y & hmask) == 13'd0) ? PART_HOR0 : PART_HOR1;
        end else if (lw4 + 4'd1 == lh4) begin
            part = ((pos_x & vmask) == 13'd0) ? PART_VER0 : PART_VER1;
        end else begin
            shape_ok = 1'b0;
        end
        big      = (log2_width > log2_height) ? log2_width : log2_height;
        depth_ok = ({1'b0, big} >= 4'd2) && ({1'b0, big} <= 4'(CTU_LOG2));
        depth    = 4'(CTU_LOG2) - {1'b0, big};
        tree_ok  = {1'b0, tree} < 2'(TREES);
        quad     = {pos_y[big], pos_x[big]};
        found    = shape_ok && depth_ok && tree_ok;
        td       = IDX_W'(tree) * IDX_W'(DEPTHS) + IDX_W'(depth);
        tdq      = td * IDX_W'(QUADS) + IDX_W'(quad);
        idx      = tdq * IDX_W'(PARTS) + IDX_W'(part);
    end

endmodule

// File: hw/rtl/coding_block_result_cache.sv
// ----------------------------------------------------------------------------
// coding_block_result_cache
// Cache of encoder coding-block results, one entry per tree, depth, quadrant
// and partition, with sticky feature bits and a few payload slots per entry.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one request: lookup, store or invalidate.
//   m_valid/m_ready/m_data return exactly one result per request, in order.
//   Each request walks a fixed sequence: metadata read, modify/write back,
//   a payload read (lookups that map to an entry only), then the result
//   moves to the output register. The next request is accepted in the
//   cycle the result enters the output register, so the block does not
//   take a new request before the current one is through. The pace is set
//   by the registered read data of the metadata and payload memories.
//   Metadata (features, slot valid bits) and payloads live in two RAMs; a
//   per-entry live bit in flops qualifies the metadata, so reset and an
//   invalidate clear entries at once with no clearing pass.
//   When the receiver stalls, the result waits in the output register and
//   the block holds the following request until that register frees up.
// ----------------------------------------------------------------------------
module coding_block_result_cache
    import cbrc_pkg::*;
#(
    parameter int SLOTS        = 2,
    parameter int TREES        = 2,
    parameter int CTU_LOG2     = 6,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cbrc_req_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cbrc_rsp_t m_data
);

    localparam int DEPTHS  = CTU_LOG2 - 1;
    localparam int ENTRIES = TREES * DEPTHS * PER_DEPTH;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PADDR_W = $clog2(ENTRIES * SLOTS);
    localparam int KEEP_W  = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int META_W  = FEAT_W + SLOTS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_META = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_PAY  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    cbrc_req_t          req_reg;
    cbrc_rsp_t          rsp_reg, rsp_next;
    logic               m_valid_reg, m_valid_next;
    cbrc_rsp_t          m_data_reg;
    logic [ENTRIES-1:0] entry_live_reg, entry_live_next;
    logic [ENTRIES-1:0] clear_vec;

    logic               loc_found;
    logic [IDX_W-1:0]   loc_idx;
    logic [META_W-1:0]  meta_rdata;
    logic [META_W-1:0]  meta_old;
    logic [META_W-1:0]  meta_wdata;
    logic [FEAT_W-1:0]  feat_old;
    logic [FEAT_W-1:0]  feat_new;
    logic [SLOTS-1:0]   sv_old;
    logic [SLOTS-1:0]   sv_new;
    logic [KEEP_W-1:0]  pay_rdata;
    logic [PADDR_W-1:0] pay_base;
    logic [PADDR_W-1:0] pay_waddr;
    logic [PADDR_W-1:0] pay_raddr;
    logic [SLOT_W-1:0]  free_sel;
    logic [SLOT_W-1:0]  hit_sel;
    logic               free_any;
    logic               hit_any;
    logic               tree_ok;
    logic               out_free;
    logic               do_store;
    logic               do_inval;
    logic               s_fire;

    cbrc_locate #(
        .CTU_LOG2 (CTU_LOG2),
        .TREES    (TREES),
        .IDX_W    (IDX_W)
    ) u_locate (
        .tree        (req_reg.tree),
        .pos_x       (req_reg.pos_x),
        .pos_y       (req_reg.pos_y),
        .log2_width  (req_reg.log2_width),
        .log2_height (req_reg.log2_height),
        .found       (loc_found),
        .idx         (loc_idx)
    );

    cbrc_ram #(
        .WIDTH (META_W),
        .DEPTH (ENTRIES)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (do_store),
        .waddr (loc_idx),
        .wdata (meta_wdata),
        .raddr (loc_idx),
        .rdata (meta_rdata)
    );

    cbrc_ram #(
        .WIDTH (KEEP_W),
        .DEPTH (ENTRIES * SLOTS)
    ) u_pay_ram (
        .aclk  (aclk),
        .we    (do_store && free_any),
        .waddr (pay_waddr),
        .wdata (KEEP_W'(req_reg.payload)),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || (state_reg == ST_DONE && out_free);
    assign s_fire   = s_valid && s_ready;
    assign tree_ok  = {1'b0, req_reg.tree} < 2'(TREES);
    assign do_store = (state_reg == ST_MOD) && (req_reg.kind == KIND_STORE) && loc_found;
    assign do_inval = (state_reg == ST_MOD) && (req_reg.kind == KIND_INVAL) && tree_ok;

    // metadata is only trusted while the entry's live bit is set
    always_comb begin
        meta_old = entry_live_reg[loc_idx] ? meta_rdata : '0;
        feat_old = meta_old[FEAT_W-1:0];
        sv_old   = meta_old[META_W-1:FEAT_W];
        free_any = 1'b0;
        free_sel = '0;
        hit_any  = 1'b0;
        hit_sel  = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!sv_old[s]) begin
                free_any = 1'b1;
                free_sel = SLOT_W'(s);
            end
            if (sv_old[s]) begin
                hit_any = 1'b1;
                hit_sel = SLOT_W'(s);
            end
        end
        feat_new             = feat_old;
        feat_new[FEAT_INTRA] = feat_old[FEAT_INTRA] | req_reg.is_intra;
        feat_new[FEAT_INTER] = feat_old[FEAT_INTER] | req_reg.is_inter;
        feat_new[FEAT_SKIP]  = feat_old[FEAT_SKIP] | req_reg.skip_flag;
        sv_new     = free_any ? (sv_old | (SLOTS'(1) << free_sel)) : sv_old;
        meta_wdata = {sv_new, feat_new};
        pay_base   = PADDR_W'(loc_idx) * PADDR_W'(SLOTS);
        pay_waddr  = pay_base + PADDR_W'(free_sel);
        pay_raddr  = pay_base + PADDR_W'(hit_sel);
    end

    // entries of the cleared depth(s) of the chosen tree
    for (genvar i = 0; i < ENTRIES; i++) begin : g_clear
        localparam int ET = i / (DEPTHS * PER_DEPTH);
        localparam int ED = (i / PER_DEPTH) % DEPTHS;
        assign clear_vec[i] = do_inval && (req_reg.tree == 1'(ET)) &&
            ((req_reg.clr_depth == 3'd0 && ED == 0) ||
             ({1'b0, req_reg.clr_depth} + 4'd1 == 4'(ED)));
    end

    always_comb begin
        entry_live_next = entry_live_reg & ~clear_vec;
        if (do_store) begin
            entry_live_next[loc_idx] = 1'b1;
        end
    end

    always_comb begin
        rsp_next = '0;
        if (loc_found && req_reg.kind == KIND_LOOKUP) begin
            rsp_next.found     = 1'b1;
            rsp_next.hit       = hit_any;
            rsp_next.saw_intra = feat_old[FEAT_INTRA];
            rsp_next.saw_inter = feat_old[FEAT_INTER];
            rsp_next.saw_skip  = feat_old[FEAT_SKIP];
        end else if (loc_found && req_reg.kind == KIND_STORE) begin
            rsp_next.found  = 1'b1;
            rsp_next.stored = free_any;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_META;
                end
            end
            ST_META: state_next = ST_MOD;
            ST_MOD: begin
                if (loc_found && req_reg.kind == KIND_LOOKUP) begin
                    state_next = ST_PAY;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PAY: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = s_valid ? ST_META : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (state_reg == ST_DONE && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            entry_live_reg <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            entry_live_reg <= entry_live_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= s_data;
        end
        if (state_reg == ST_MOD) begin
            rsp_reg <= rsp_next;
        end
        // drop the payload in when the lookup hit
        if (state_reg == ST_PAY) begin
            rsp_reg.cached_payload <= rsp_reg.hit ? 32'(pay_rdata) : 32'd0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= rsp_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the done state");

    a_store_marks_live: assert property (@(posedge aclk) disable iff (!aresetn)
        do_store |=> entry_live_reg[$past(loc_idx)])
        else $error("stored entry not marked live");

    a_hit_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.hit) |-> (m_data_reg.found && !m_data_reg.stored))
        else $error("hit reported without a mapped lookup");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD || state_reg == ST_PAY) |-> !s_ready)
        else $error("request accepted while one is in flight");

endmodule

// File: tb/cache_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_result_checker
// Watches the request and result channels of the coding-block result cache.
// Keeps its own copy of the entry table, works out the result of every
// accepted request and compares each returned result with the oldest one due.
// ----------------------------------------------------------------------------
module cache_result_checker
    import cbrc_pkg::*;
#(
    parameter int SLOTS        = 2,
    parameter int TREES        = 2,
    parameter int CTU_LOG2     = 6,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  cbrc_req_t s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  cbrc_rsp_t m_data,
    output int        fail_count,
    output int        expected_left
);

    localparam int DEPTHS  = CTU_LOG2 - 1;
    localparam int ENTRIES = TREES * DEPTHS * PER_DEPTH;
    localparam logic [31:0] KEEP_MASK = (PAYLOAD_BITS >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << PAYLOAD_BITS) - 1);

    typedef struct packed {
        logic live;
        logic intra;
        logic inter;
        logic skip;
    } entry_flags_t;

    entry_flags_t     entry_flags [ENTRIES];
    logic [SLOTS-1:0] slot_used   [ENTRIES];
    logic [31:0]      slot_word   [ENTRIES][SLOTS];
    cbrc_rsp_t        awaited     [$];

    // Map a block shape to its entry, or -1 when the shape has none.
    function automatic int entry_of(cbrc_req_t r);
        int lw;
        int lh;
        int big;
        int depth;
        int quad;
        int part;
        if (int'(r.tree) >= TREES) return -1;
        lw = int'(r.log2_width);
        lh = int'(r.log2_height);
        if (lw == lh) begin
            part = PART_FULL;
        end else if (lw == lh + 1) begin
            part = ((int'(r.pos_y) & ((1 << (lh + 1)) - 1)) == 0) ? PART_HOR0 : PART_HOR1;
        end else if (lw + 1 == lh) begin
            part = ((int'(r.pos_x) & ((1 << (lw + 1)) - 1)) == 0) ? PART_VER0 : PART_VER1;
        end else begin
            return -1;
        end
        big   = (lw > lh) ? lw : lh;
        depth = CTU_LOG2 - big;
        if (depth < 0 || depth >= DEPTHS) return -1;
        quad = ((int'(r.pos_y) >> big) & 1) * 2 + ((int'(r.pos_x) >> big) & 1);
        return ((int'(r.tree) * DEPTHS + depth) * QUADS + quad) * PARTS + part;
    endfunction

    function automatic void wipe_depth(int tree, int depth);
        int base;
        base = (tree * DEPTHS + depth) * PER_DEPTH;
        for (int i = 0; i < PER_DEPTH; i++) begin
            entry_flags[base + i] = '0;
            slot_used[base + i]   = '0;
        end
    endfunction

    // Apply one request to the table and return the result it produces.
    function automatic cbrc_rsp_t cache_response(cbrc_req_t r);
        cbrc_rsp_t rsp;
        int        idx;
        int        cd;
        rsp = '0;
        case (r.kind)
            KIND_INVAL: begin
                cd = int'(r.clr_depth);
                if (int'(r.tree) < TREES) begin
                    if (cd == 0) wipe_depth(int'(r.tree), 0);
                    if (cd + 1 < DEPTHS) wipe_depth(int'(r.tree), cd + 1);
                end
            end
            KIND_LOOKUP, KIND_STORE: begin
                idx = entry_of(r);
                if (idx >= 0) begin
                    rsp.found = 1'b1;
                    if (r.kind == KIND_LOOKUP) begin
                        if (entry_flags[idx].live) begin
                            rsp.saw_intra = entry_flags[idx].intra;
                            rsp.saw_inter = entry_flags[idx].inter;
                            rsp.saw_skip  = entry_flags[idx].skip;
                        end
                        for (int s = 0; s < SLOTS; s++) begin
                            if (!rsp.hit && slot_used[idx][s]) begin
                                rsp.hit            = 1'b1;
                                rsp.cached_payload = slot_word[idx][s];
                            end
                        end
                    end else begin
                        // feature bits stick even when every slot is taken
                        entry_flags[idx].live = 1'b1;
                        if (r.is_intra)  entry_flags[idx].intra = 1'b1;
                        if (r.is_inter)  entry_flags[idx].inter = 1'b1;
                        if (r.skip_flag) entry_flags[idx].skip  = 1'b1;
                        for (int s = 0; s < SLOTS; s++) begin
                            if (!rsp.stored && !slot_used[idx][s]) begin
                                slot_used[idx][s] = 1'b1;
                                slot_word[idx][s] = r.payload & KEEP_MASK;
                                rsp.stored        = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", field, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        cbrc_rsp_t want;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                entry_flags[i] = '0;
                slot_used[i]   = '0;
            end
            awaited.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    $error("result returned with no request outstanding");
                    fail_count++;
                end else begin
                    want = awaited.pop_front();
                    check_field("found", 32'(want.found), 32'(m_data.found));
                    check_field("hit", 32'(want.hit), 32'(m_data.hit));
                    check_field("cached_payload", want.cached_payload,
                                m_data.cached_payload);
                    check_field("saw_intra", 32'(want.saw_intra), 32'(m_data.saw_intra));
                    check_field("saw_inter", 32'(want.saw_inter), 32'(m_data.saw_inter));
                    check_field("saw_skip", 32'(want.saw_skip), 32'(m_data.saw_skip));
                    check_field("stored", 32'(want.stored), 32'(m_data.stored));
                end
            end
            if (s_valid && s_ready) awaited.push_back(cache_response(s_data));
        end
        expected_left = awaited.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the coding-block result cache with directed and random requests
// under random stalls on both channels and gives the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
    import cbrc_pkg::*;

    localparam int SLOTS          = 2;
    localparam int TREES          = 2;
    localparam int CTU_LOG2       = 6;
    localparam int PAYLOAD_BITS   = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    // feature flags of a stored block: {intra, inter, skip}
    localparam logic [2:0] CU_NONE  = 3'b000;
    localparam logic [2:0] CU_INTRA = 3'b100;
    localparam logic [2:0] CU_INTER = 3'b010;
    localparam logic [2:0] CU_SKIP  = 3'b001;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    cbrc_req_t s_data;
    logic      m_valid;
    logic      m_ready;
    cbrc_rsp_t m_data;

    int fail_count;
    int expected_left;
    int quiet_cycles;
    int hold_asked;
    int hold_served;
    bit idle_off;

    coding_block_result_cache #(
        .SLOTS(SLOTS), .TREES(TREES), .CTU_LOG2(CTU_LOG2), .PAYLOAD_BITS(PAYLOAD_BITS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    cache_result_checker #(
        .SLOTS(SLOTS), .TREES(TREES), .CTU_LOG2(CTU_LOG2), .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_result_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .expected_left(expected_left)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic cbrc_req_t block_req(logic [1:0] kind, logic tree, int x, int y,
                                            int lw, int lh, logic [2:0] flags,
                                            logic [31:0] word);
        cbrc_req_t r;
        r             = '0;
        r.kind        = kind;
        r.tree        = tree;
        r.pos_x       = 13'(x);
        r.pos_y       = 13'(y);
        r.log2_width  = 3'(lw);
        r.log2_height = 3'(lh);
        r.is_intra    = flags[2];
        r.is_inter    = flags[1];
        r.skip_flag   = flags[0];
        r.payload     = word;
        return r;
    endfunction

    function automatic cbrc_req_t clear_req(logic tree, int cd);
        cbrc_req_t r;
        r           = '0;
        r.kind      = KIND_INVAL;
        r.tree      = tree;
        r.clr_depth = 3'(cd);
        return r;
    endfunction

    // Mostly well-formed lookups and stores on aligned blocks; some noise.
    function automatic cbrc_req_t random_req();
        cbrc_req_t    r;
        logic [95:0]  noise;
        logic [12:0]  align;
        int           p;
        int           big;
        int           form;
        noise = {$urandom(), $urandom(), $urandom()};
        r     = noise[$bits(cbrc_req_t)-1:0];
        p     = $urandom_range(0, 99);
        if (p < 5) return r;
        if (p >= 87) begin
            r.kind      = KIND_INVAL;
            r.clr_depth = ($urandom_range(0, 9) == 0) ? 3'($urandom()) :
                                                        3'($urandom_range(0, 4));
            return r;
        end
        r.kind = (p < 47) ? KIND_LOOKUP : KIND_STORE;
        big    = $urandom_range(2, CTU_LOG2);
        form   = $urandom_range(0, 4);
        if ($urandom_range(0, 4) != 0) begin
            align   = 13'((1 << big) - 1);
            r.pos_x = r.pos_x & ~align;
            r.pos_y = r.pos_y & ~align;
            if (form == 2) r.pos_y = r.pos_y | 13'(1 << (big - 1));
            if (form == 4) r.pos_x = r.pos_x | 13'(1 << (big - 1));
        end
        r.log2_width  = 3'((form == 3 || form == 4) ? big - 1 : big);
        r.log2_height = 3'((form == 1 || form == 2) ? big - 1 : big);
        return r;
    endfunction

    task automatic offer(cbrc_req_t r);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        gap = idle_off ? 0 : idle_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic offer_random(int count);
        repeat (count) offer(random_req());
    endtask

    // receiver: random bursts and stalls, or a long hold-off when asked
    initial begin
        int run;
        int gap;
        m_ready = 1'b0;
        do @(negedge aclk); while (!aresetn);
        forever begin
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (idle_off) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                run = $urandom_range(1, 12);
                @(negedge aclk);
                m_ready <= 1'b1;
                repeat (run - 1) @(negedge aclk);
                gap = idle_gap();
                if (gap > 0) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        hold_asked  = 0;
        hold_served = 0;
        idle_off    = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // fill one CTU-sized entry past its slot count
        offer(block_req(KIND_LOOKUP, 1'b0, 0, 0, 6, 6, CU_NONE, 32'h0));
        offer(block_req(KIND_STORE, 1'b0, 0, 0, 6, 6, CU_INTRA, 32'hFFFF_FFFF));
        offer(block_req(KIND_STORE, 1'b0, 0, 0, 6, 6, CU_INTER | CU_SKIP, 32'h0));
        offer(block_req(KIND_STORE, 1'b0, 0, 0, 6, 6, CU_INTRA | CU_INTER | CU_SKIP,
                        32'h1234_5678));
        offer(block_req(KIND_LOOKUP, 1'b0, 0, 0, 6, 6, CU_NONE, 32'h0));
        // smallest block at the far picture corner, chroma tree
        offer(block_req(KIND_STORE, 1'b1, 8191, 8191, 2, 2, CU_NONE, 32'hA5A5_A5A5));
        offer(block_req(KIND_LOOKUP, 1'b1, 8188, 8188, 2, 2, CU_NONE, 32'h0));
        // both halves of both binary splits
        offer(block_req(KIND_STORE, 1'b0, 0, 0, 6, 5, CU_SKIP, 32'h0000_0011));
        offer(block_req(KIND_STORE, 1'b0, 0, 32, 6, 5, CU_INTER, 32'h0000_0022));
        offer(block_req(KIND_STORE, 1'b0, 0, 0, 5, 6, CU_INTRA, 32'h0000_0033));
        offer(block_req(KIND_STORE, 1'b0, 32, 0, 5, 6, CU_SKIP, 32'h0000_0044));
        offer(block_req(KIND_LOOKUP, 1'b0, 0, 32, 6, 5, CU_NONE, 32'h0));
        offer(block_req(KIND_LOOKUP, 1'b0, 32, 0, 5, 6, CU_NONE, 32'h0));
        // shapes with no entry, and the unused kind
        offer(block_req(KIND_LOOKUP, 1'b0, 0, 0, 6, 4, CU_NONE, 32'h0));
        offer(block_req(KIND_LOOKUP, 1'b0, 0, 0, 7, 7, CU_NONE, 32'h0));
        offer(block_req(KIND_STORE, 1'b0, 0, 0, 1, 1, CU_INTRA, 32'h0BAD_0BAD));
        offer(block_req(KIND_LOOKUP, 1'b0, 0, 0, 0, 0, CU_NONE, 32'h0));
        offer(block_req(KIND_NONE, 1'b1, 8191, 8191, 7, 7, CU_INTRA, 32'hFFFF_FFFF));
        // depth zero clears the top two depths
        offer(clear_req(1'b0, 0));
        offer(block_req(KIND_LOOKUP, 1'b0, 0, 0, 6, 6, CU_NONE, 32'h0));
        // clears past the last depth do nothing
        offer(clear_req(1'b1, 7));
        offer(clear_req(1'b1, 4));
        offer(block_req(KIND_LOOKUP, 1'b1, 8191, 8191, 2, 2, CU_NONE, 32'h0));
        offer(clear_req(1'b1, 3));
        offer(block_req(KIND_LOOKUP, 1'b1, 8191, 8191, 2, 2, CU_NONE, 32'h0));

        offer_random(220);

        // back-to-back requests against a receiver that holds off
        idle_off = 1'b1;
        hold_asked++;
        offer_random(24);

        // pause until every result is back, then stream with no gaps
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_left != 0) @(negedge aclk);
        offer_random(150);
        idle_off = 1'b0;

        offer_random(200);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_left != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
